// File: src/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared types and constants for the adaptive beat detector
// Sequencer states, configuration register map, reset values and the fixed
// field widths that do not follow the peak width.
// ----------------------------------------------------------------------------
package abd_pkg;

  // fixed field widths
  localparam int CFG_W    = 16;  // configuration write data
  localparam int IDX_W    = 3;   // configuration register index
  localparam int FRAMES_W = 8;   // frames per averaging block
  localparam int TIME_W   = 32;  // millisecond timestamp
  localparam int HOLD_W   = 17;  // hold counter
  localparam int DECAY_W  = 16;  // decay factor, Q0.16

  // configuration register map
  localparam logic [IDX_W-1:0] REG_AVERAGE_FRAMES = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOCKOUT_MS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_HOLD_FRAMES    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DECAY_FACTOR   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BEAT_FLOOR     = 3'd4;

  // reset values of the configuration registers
  localparam logic [FRAMES_W-1:0] RST_AVERAGE_FRAMES = 8'd16;
  localparam logic [CFG_W-1:0]    RST_LOCKOUT_MS     = 16'd300;
  localparam logic [CFG_W-1:0]    RST_HOLD_FRAMES    = 16'd40;
  localparam logic [DECAY_W-1:0]  RST_DECAY_FACTOR   = 16'd63898;
  localparam logic [CFG_W-1:0]    RST_BEAT_FLOOR     = 16'd9830;

  // beat cutoff is peak * 11 / 10
  localparam int BEAT_MUL = 11;
  localparam logic [FRAMES_W-1:0] BEAT_DIV = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_DECIDE,
    ST_DIV_CUT,
    ST_DECAY,
    ST_FINISH
  } abd_state_e;

endpackage

// File: src/adaptive_beat_detector.sv
// ----------------------------------------------------------------------------
// adaptive_beat_detector: adaptive threshold beat detector
// Flags beats in a stream of frame peak levels against a decaying cutoff,
// a floor and a running block average, with a lockout after each beat.
// ----------------------------------------------------------------------------
// One word is taken at a time. A plain frame goes from the idle state through
// the decide and finish steps. When the word closes an averaging block, a
// divide step comes first, in which the stored block sum is divided
// bit-serially by the frame count. When it is a beat, the same divider forms
// peak*11/10; when the cutoff decays instead, a bit-serial multiply by the
// Q0.16 decay factor runs. Both sit between the decide and finish steps and
// use the shared restoring divider and the shift-add multiplier. The input is
// stalled while a word is being worked on; a finished result sits in an output
// register, so the next word is taken while the previous result still waits
// for the consumer. Configuration is written through a plain write port and
// must only be changed while the block is idle.
module adaptive_beat_detector
  import abd_pkg::*;
#(
  parameter int PEAK_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PEAK_BITS-1:0] peak_level_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 beat_o,
  output logic [PEAK_BITS:0]   cutoff_level_o,
  output logic [PEAK_BITS-1:0] average_level_o
);

  localparam int SW    = PEAK_BITS + FRAMES_W;  // block sum and divider width
  localparam int CW    = PEAK_BITS + 1;         // cutoff width
  localparam int P11_W = PEAK_BITS + 4;         // peak * 11
  localparam int CNT_W = $clog2(SW);

  // configuration registers
  logic [FRAMES_W-1:0] avg_frames_q;
  logic [CFG_W-1:0]    lockout_q;
  logic [CFG_W-1:0]    hold_frames_q;
  logic [DECAY_W-1:0]  decay_q;
  logic [CFG_W-1:0]    floor_q;

  // detector state
  abd_state_e          state_q, state_d;
  logic [PEAK_BITS-1:0] average_peak_q, average_peak_d;
  logic [SW-1:0]        peak_sum_q, peak_sum_d;
  logic [FRAMES_W-1:0]  fib_q, fib_d;
  logic [CW-1:0]        cutoff_q, cutoff_d;
  logic [HOLD_W-1:0]    hold_cnt_q, hold_cnt_d;
  logic [TIME_W-1:0]    last_beat_q, last_beat_d;
  logic                 beat_q, beat_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  // working payload
  logic [PEAK_BITS-1:0] peak_q, peak_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic [SW-1:0]        sh_q, sh_d;      // dividend/quotient or multiplier bits
  logic [FRAMES_W-1:0]  rem_q, rem_d;    // partial remainder
  logic [FRAMES_W-1:0]  dvsr_q, dvsr_d;  // divisor
  logic [CW-1:0]        acc_q, acc_d;    // product high part

  // result register
  logic                 out_beat_q, out_beat_d;
  logic [CW-1:0]        out_cutoff_q, out_cutoff_d;
  logic [PEAK_BITS-1:0] out_avg_q, out_avg_d;

  // datapath
  logic [FRAMES_W-1:0]  frames;
  logic [PEAK_BITS-1:0] floor_v;
  logic [CW-1:0]        floor_cw;
  logic [FRAMES_W:0]    rem_sh, rem_sub;
  logic                 rem_ge;
  logic [FRAMES_W-1:0]  rem_next;
  logic [SW-1:0]        sh_next;
  logic [PEAK_BITS-1:0] quot_sat;
  logic [CW:0]          mul_sum;
  logic [CW-1:0]        decayed, decay_floored;
  logic [TIME_W-1:0]    elapsed;
  logic                 beat_hit;
  logic [P11_W-1:0]     peak11;
  logic                 last_step;

  // a block length of zero acts as one
  assign frames   = (avg_frames_q == '0) ? FRAMES_W'(1) : avg_frames_q;
  // the floor is taken at peak width
  assign floor_v  = PEAK_BITS'(floor_q);
  assign floor_cw = CW'(floor_v);

  // one restoring divide step: bring down the next dividend bit, subtract
  // the divisor where it fits and shift the quotient bit in at the bottom
  assign rem_sh   = {rem_q, sh_q[SW-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvsr_q};
  assign rem_sub  = rem_sh - {1'b0, dvsr_q};
  assign rem_next = rem_ge ? rem_sub[FRAMES_W-1:0] : rem_sh[FRAMES_W-1:0];
  assign sh_next  = {sh_q[SW-2:0], rem_ge};

  // the quotient can exceed the peak range when the block length was lowered
  // mid-block: saturate
  assign quot_sat = (|sh_next[SW-1:PEAK_BITS]) ? '1 : sh_next[PEAK_BITS-1:0];

  // one shift-add multiply step, decay factor bits taken LSB first; the low
  // product bits drop off the bottom, leaving cutoff * decay >> 16
  assign mul_sum       = {1'b0, acc_q} + (sh_q[0] ? {1'b0, cutoff_q} : '0);
  assign decayed       = mul_sum[CW:1];
  assign decay_floored = (decayed < floor_cw) ? floor_cw : decayed;

  // beat test, timestamps differenced modulo 2^32
  assign elapsed  = now_q - last_beat_q;
  assign beat_hit = (elapsed > TIME_W'(lockout_q)) &&
                    ({1'b0, peak_q} > cutoff_q) &&
                    (peak_q > floor_v) &&
                    (peak_q > average_peak_q);

  assign peak11    = P11_W'(peak_q) * P11_W'(BEAT_MUL);
  assign last_step = (cnt_q == '0);

  // the sequencer takes a word only when idle
  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign beat_o          = out_beat_q;
  assign cutoff_level_o  = out_cutoff_q;
  assign average_level_o = out_avg_q;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_frames_q  <= RST_AVERAGE_FRAMES;
      lockout_q     <= RST_LOCKOUT_MS;
      hold_frames_q <= RST_HOLD_FRAMES;
      decay_q       <= RST_DECAY_FACTOR;
      floor_q       <= RST_BEAT_FLOOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AVERAGE_FRAMES: avg_frames_q  <= cfg_wdata_i[FRAMES_W-1:0];
        REG_LOCKOUT_MS:     lockout_q     <= cfg_wdata_i;
        REG_HOLD_FRAMES:    hold_frames_q <= cfg_wdata_i;
        REG_DECAY_FACTOR:   decay_q       <= cfg_wdata_i[DECAY_W-1:0];
        REG_BEAT_FLOOR:     floor_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      average_peak_q <= '0;
      peak_sum_q     <= '0;
      fib_q          <= '0;
      cutoff_q       <= '0;
      hold_cnt_q     <= '0;
      last_beat_q    <= '0;
      beat_q         <= 1'b0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      average_peak_q <= average_peak_d;
      peak_sum_q     <= peak_sum_d;
      fib_q          <= fib_d;
      cutoff_q       <= cutoff_d;
      hold_cnt_q     <= hold_cnt_d;
      last_beat_q    <= last_beat_d;
      beat_q         <= beat_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    peak_q       <= peak_d;
    now_q        <= now_d;
    sh_q         <= sh_d;
    rem_q        <= rem_d;
    dvsr_q       <= dvsr_d;
    acc_q        <= acc_d;
    out_beat_q   <= out_beat_d;
    out_cutoff_q <= out_cutoff_d;
    out_avg_q    <= out_avg_d;
  end

  // next state and datapath control
  always_comb begin
    state_d        = state_q;
    average_peak_d = average_peak_q;
    peak_sum_d     = peak_sum_q;
    fib_d          = fib_q;
    cutoff_d       = cutoff_q;
    hold_cnt_d     = hold_cnt_q;
    last_beat_d    = last_beat_q;
    beat_d         = beat_q;
    cnt_d          = cnt_q;
    peak_d         = peak_q;
    now_d          = now_q;
    sh_d           = sh_q;
    rem_d          = rem_q;
    dvsr_d         = dvsr_q;
    acc_d          = acc_q;
    out_beat_d     = out_beat_q;
    out_cutoff_d   = out_cutoff_q;
    out_avg_d      = out_avg_q;
    // drop the result once the consumer has taken it
    out_valid_d    = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          peak_d = peak_level_i;
          now_d  = now_ms_i;
          beat_d = 1'b0;
          if (fib_q >= frames) begin
            // block full: divide the old sum, start a new block with this frame
            sh_d       = peak_sum_q;
            rem_d      = '0;
            dvsr_d     = frames;
            cnt_d      = CNT_W'(SW - 1);
            peak_sum_d = SW'(peak_level_i);
            fib_d      = FRAMES_W'(1);
            state_d    = ST_DIV_AVG;
          end else begin
            peak_sum_d = peak_sum_q + SW'(peak_level_i);
            fib_d      = fib_q + FRAMES_W'(1);
            state_d    = ST_DECIDE;
          end
        end
      end
      ST_DIV_AVG: begin
        sh_d  = sh_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CNT_W'(1);
        if (last_step) begin
          average_peak_d = quot_sat;
          state_d        = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (beat_hit) begin
          beat_d      = 1'b1;
          last_beat_d = now_q;
          hold_cnt_d  = '0;
          sh_d        = SW'(peak11);
          rem_d       = '0;
          dvsr_d      = BEAT_DIV;
          cnt_d       = CNT_W'(SW - 1);
          state_d     = ST_DIV_CUT;
        end else if (hold_cnt_q <= HOLD_W'(hold_frames_q)) begin
          hold_cnt_d = hold_cnt_q + HOLD_W'(1);
          state_d    = ST_FINISH;
        end else begin
          acc_d   = '0;
          sh_d    = SW'(decay_q);
          cnt_d   = CNT_W'(DECAY_W - 1);
          state_d = ST_DECAY;
        end
      end
      ST_DIV_CUT: begin
        sh_d  = sh_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CNT_W'(1);
        if (last_step) begin
          cutoff_d = sh_next[CW-1:0];
          state_d  = ST_FINISH;
        end
      end
      ST_DECAY: begin
        acc_d = decayed;
        sh_d  = sh_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (last_step) begin
          cutoff_d = decay_floored;
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_beat_d   = beat_q;
          out_cutoff_d = cutoff_q;
          out_avg_d    = average_peak_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  // the partial remainder stays below a non-zero divisor while dividing
  a_rem_below_dvsr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_AVG || state_q == ST_DIV_CUT) |-> (rem_q < dvsr_q))
    else $error("divider remainder not below divisor");

  // an accepted word starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  // a result only appears out of the finishing step
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside the finishing step");

  // a beat cutoff is at least the peak, which beat the average
  a_beat_cutoff_above_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q) |-> (out_cutoff_q > {1'b0, out_avg_q}))
    else $error("beat reported with cutoff not above the average");
`endif

endmodule

// File: sim/beat_checker.sv
// ----------------------------------------------------------------------------
// beat_checker: result checker for the adaptive beat detector
// Watches the configuration port and both word channels, keeps its own copy
// of the detector state, predicts one result word per accepted input word
// and compares every delivered result word field by field, in order.
// ----------------------------------------------------------------------------
module beat_checker
  import abd_pkg::*;
#(
  parameter int PEAK_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [PEAK_BITS-1:0] peak_level_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 beat_i,
  input  logic [PEAK_BITS:0]   cutoff_level_i,
  input  logic [PEAK_BITS-1:0] average_level_i,
  output int                   mismatches_o,
  output int                   due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_W   = PEAK_BITS + 8;
  localparam int CUT_W   = PEAK_BITS + 1;
  localparam int CUT_NUM = 11;  // beat cutoff is 1.1 times the peak
  localparam int CUT_DEN = 10;

  typedef struct packed {
    logic                 beat;
    logic [CUT_W-1:0]     cutoff;
    logic [PEAK_BITS-1:0] average;
  } beat_result_t;

  // register copies
  logic [FRAMES_W-1:0] frames_per_block;
  logic [CFG_W-1:0]    lockout_span;
  logic [CFG_W-1:0]    hold_span;
  logic [DECAY_W-1:0]  decay_mul;
  logic [CFG_W-1:0]    floor_word;

  // detector state
  logic [PEAK_BITS-1:0] block_average;
  logic [SUM_W-1:0]     block_sum;
  logic [FRAMES_W-1:0]  block_count;
  logic [CUT_W-1:0]     cutoff_now;
  logic [HOLD_W-1:0]    frames_held;
  logic [TIME_W-1:0]    last_beat_at;

  beat_result_t results_due[$];
  int mismatches = 0;
  int due        = 0;

  assign mismatches_o = mismatches;
  assign due_o        = due;

  // advance the detector by one frame and return the word it should emit
  function automatic beat_result_t detect_frame(input logic [PEAK_BITS-1:0] peak,
                                                input logic [TIME_W-1:0]    now);
    logic [FRAMES_W-1:0]  frames;
    logic [SUM_W-1:0]     quot;
    logic [TIME_W-1:0]    elapsed;
    logic [63:0]          wide;
    logic [PEAK_BITS-1:0] floor_lvl;
    beat_result_t         res;
    floor_lvl = PEAK_BITS'(floor_word);
    frames    = (frames_per_block == '0) ? FRAMES_W'(1) : frames_per_block;
    if (block_count >= frames) begin
      quot          = block_sum / SUM_W'(frames);
      block_average = (|(quot >> PEAK_BITS)) ? '1 : quot[PEAK_BITS-1:0];
      block_sum     = '0;
      block_count   = '0;
    end
    block_sum   = block_sum + SUM_W'(peak);
    block_count = block_count + 1'b1;

    elapsed  = now - last_beat_at;
    res.beat = 1'b0;
    if (elapsed > TIME_W'(lockout_span) && CUT_W'(peak) > cutoff_now &&
        peak > floor_lvl && peak > block_average) begin
      res.beat     = 1'b1;
      wide         = (64'(peak) * CUT_NUM) / CUT_DEN;
      cutoff_now   = wide[CUT_W-1:0];
      last_beat_at = now;
      frames_held  = '0;
    end else if (frames_held <= HOLD_W'(hold_span)) begin
      frames_held = frames_held + 1'b1;
    end else begin
      wide       = (64'(cutoff_now) * 64'(decay_mul)) >> 16;
      cutoff_now = wide[CUT_W-1:0];
      if (cutoff_now < CUT_W'(floor_lvl)) cutoff_now = CUT_W'(floor_lvl);
    end
    res.cutoff  = cutoff_now;
    res.average = block_average;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_result_t want;
    if (!rst_ni) begin
      frames_per_block = RST_AVERAGE_FRAMES;
      lockout_span     = RST_LOCKOUT_MS;
      hold_span        = RST_HOLD_FRAMES;
      decay_mul        = RST_DECAY_FACTOR;
      floor_word       = RST_BEAT_FLOOR;
      block_average    = '0;
      block_sum        = '0;
      block_count      = '0;
      cutoff_now       = '0;
      frames_held      = '0;
      last_beat_at     = '0;
      results_due.delete();
    end else begin
      // the result leaving now belongs to an earlier word, so retire it first
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing due: beat %0b cutoff %0d average %0d",
                   $time, beat_i, cutoff_level_i, average_level_i);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (beat_i !== want.beat) begin
            $display("%0t: beat expected %0b actual %0b", $time, want.beat, beat_i);
            mismatches++;
          end
          if (cutoff_level_i !== want.cutoff) begin
            $display("%0t: cutoff_level expected %0d actual %0d",
                     $time, want.cutoff, cutoff_level_i);
            mismatches++;
          end
          if (average_level_i !== want.average) begin
            $display("%0t: average_level expected %0d actual %0d",
                     $time, want.average, average_level_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AVERAGE_FRAMES: frames_per_block = cfg_wdata_i[FRAMES_W-1:0];
          REG_LOCKOUT_MS:     lockout_span     = cfg_wdata_i;
          REG_HOLD_FRAMES:    hold_span        = cfg_wdata_i;
          REG_DECAY_FACTOR:   decay_mul        = cfg_wdata_i[DECAY_W-1:0];
          REG_BEAT_FLOOR:     floor_word       = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(detect_frame(peak_level_i, now_ms_i));
    end
    due = results_due.size();
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the adaptive beat detector
// Drives a short directed run through the corner cases, then phases of
// random frame streams under changing register settings, with bursty input
// and a consumer that stalls on its own pattern. Checking is done by
// beat_checker, which sits beside the detector and reports a mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import abd_pkg::*;

  localparam int PEAK_BITS       = 16;
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 64;      // longer than the longest word takes
  localparam int HOLD_OFF_CYCLES = 400;     // long consumer hold-off, once
  localparam int DRAIN_LIMIT     = 2000;
  localparam int TIMEOUT_NS      = 8_000_000;

  typedef enum int {
    DRAIN_FREE,      // never stall
    DRAIN_RANDOM,    // stall on a coin toss each cycle
    DRAIN_PERIODIC   // stall in regular runs
  } drain_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [PEAK_BITS-1:0] peak_level_i;
  logic [TIME_W-1:0]    now_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 beat_o;
  logic [PEAK_BITS:0]   cutoff_level_o;
  logic [PEAK_BITS-1:0] average_level_o;

  int   mismatches;
  int   due;
  logic hold_off_req = 1'b0;

  adaptive_beat_detector #(.PEAK_BITS(PEAK_BITS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .peak_level_i    (peak_level_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .beat_o          (beat_o),
    .cutoff_level_o  (cutoff_level_o),
    .average_level_o (average_level_o)
  );

  beat_checker #(.PEAK_BITS(PEAK_BITS)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .peak_level_i    (peak_level_i),
    .now_ms_i        (now_ms_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .beat_i          (beat_o),
    .cutoff_level_i  (cutoff_level_o),
    .average_level_i (average_level_o),
    .mismatches_o    (mismatches),
    .due_o           (due)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // hard stop in case the handshake locks up
  initial begin
    #TIMEOUT_NS;
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one word and hold it until the detector takes it. Called at a
  // rising edge; returns at the edge where the word was accepted, with
  // valid still high so a back-to-back word needs no second assignment.
  task automatic offer_word(input logic [PEAK_BITS-1:0] peak, input logic [TIME_W-1:0] now);
    in_valid_i   <= 1'b1;
    peak_level_i <= peak;
    now_ms_i     <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // one register write per cycle; the write enable stays high across the set
  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write all five registers, then a stray write to an unmapped index,
  // which the detector must ignore.
  task automatic program_detector(input logic [CFG_W-1:0] frames_word,
                                  input logic [CFG_W-1:0] lockout,
                                  input logic [CFG_W-1:0] hold,
                                  input logic [CFG_W-1:0] decay,
                                  input logic [CFG_W-1:0] floor_lvl);
    put_reg(REG_AVERAGE_FRAMES, frames_word);
    put_reg(REG_LOCKOUT_MS, lockout);
    put_reg(REG_HOLD_FRAMES, hold);
    put_reg(REG_DECAY_FACTOR, decay);
    put_reg(REG_BEAT_FLOOR, floor_lvl);
    put_reg(IDX_W'($urandom_range(int'(REG_BEAT_FLOOR) + 1, (1 << IDX_W) - 1)),
            CFG_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and wait until every result word is home, then let the
  // detector run out before touching its registers.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // pick a register value: often an extreme, otherwise from a useful band
  function automatic logic [CFG_W-1:0] pick_setting(input int lo, input int hi,
                                                    input int band_lo, input int band_hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return CFG_W'(lo);
    if (r == 1) return CFG_W'(hi);
    return CFG_W'($urandom_range(band_lo, band_hi));
  endfunction

  // consumer: stalls on a pattern of its own, plus one long hold-off
  initial begin : consumer
    drain_mode_e mode;
    int          span;
    bit          held_off;
    held_off    = 1'b0;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !held_off) begin
        // hold off long enough for the output register to fill and the
        // input side to back up while words keep coming
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        held_off = 1'b1;
      end
      mode = drain_mode_e'($urandom_range(0, 2));
      span = $urandom_range(16, 160);
      for (int c = 0; c < span; c++) begin
        case (mode)
          DRAIN_FREE:   out_stall_i <= 1'b0;
          DRAIN_RANDOM: out_stall_i <= ($urandom_range(0, 1) == 1);
          default:      out_stall_i <= ((c % 12) < 7);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // producer: directed corner cases, then random phases, then the verdict
  initial begin : producer
    logic [TIME_W-1:0]    stamp;
    logic [PEAK_BITS-1:0] peak;
    logic [CFG_W-1:0]     frames_word, lockout, hold, decay, floor_lvl;
    int                   burst_left, gap, kind;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    peak_level_i = '0;
    now_ms_i     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, reset settings ---
    offer_word('0, '0);                  // silence at time zero, still in lockout
    offer_word('1, 32'd1000);            // full scale: beat, cutoff at its top
    offer_word('1, 32'd1100);            // blocked by the lockout
    offer_word('1, 32'd1301);            // past lockout, but not above the cutoff
    quiesce();

    // block length of zero acts as one; junk in the upper data bits is dropped;
    // the four frames already summed now overflow the average and saturate it;
    // no hold and no decay factor, so the cutoff collapses to a zero floor
    program_detector({8'hA5, 8'd0}, '0, '0, '0, '0);
    offer_word(PEAK_BITS'(1), 32'd1302);
    offer_word(PEAK_BITS'(200), 32'hFFFF_FFFF);
    offer_word(PEAK_BITS'(300), 32'h0000_0002);   // timestamp wraps across the beat
    quiesce();

    // fill part of an eight-frame block, then shrink the block mid-way so the
    // quotient runs past full scale
    program_detector(CFG_W'(8), '0, CFG_W'(1000), '1, '0);
    stamp = 32'd10;
    repeat (6) begin
      stamp += 32'd10;
      offer_word('1, stamp);
    end
    quiesce();
    program_detector(CFG_W'(1), '0, CFG_W'(1000), '1, '0);
    stamp += 32'd10;
    offer_word(PEAK_BITS'(16'h8000), stamp);
    quiesce();

    // let the hold count climb under a long hold, then lower the hold below
    // it: decay has to start on the very next frame
    program_detector(CFG_W'(4), '1, CFG_W'(1000), '1, '0);
    repeat (5) begin
      stamp += 32'd10;
      offer_word('0, stamp);
    end
    quiesce();
    program_detector(CFG_W'(4), '1, CFG_W'(2), '1, '0);
    repeat (2) begin
      stamp += 32'd10;
      offer_word('0, stamp);
    end
    quiesce();

    // --- random phases ---
    burst_left = $urandom_range(1, 32);
    stamp      = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        // every register at its low end
        frames_word = {8'($urandom), 8'd1};
        lockout     = '0;
        hold        = '0;
        decay       = '0;
        floor_lvl   = '0;
      end else if (phase == 1) begin
        // every register at its high end
        frames_word = {8'($urandom), 8'd255};
        lockout     = '1;
        hold        = '1;
        decay       = '1;
        floor_lvl   = '1;
      end else begin
        // short blocks mostly, so the average moves often
        frames_word = {8'($urandom), 8'(pick_setting(0, 255, 1, 24))};
        lockout     = pick_setting(0, 65535, 0, 400);
        hold        = pick_setting(0, 65535, 0, 60);
        decay       = pick_setting(0, 65535, 40000, 65535);
        floor_lvl   = pick_setting(0, 65535, 0, 20000);
      end
      program_detector(frames_word, lockout, hold, decay, floor_lvl);
      if (phase == 2) hold_off_req <= 1'b1;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          // noise: any peak at any time
          peak  = PEAK_BITS'($urandom);
          stamp = $urandom;
        end else begin
          // a plausible stream: time moves on by a frame or so, now and then
          // by a long silence; mostly background with the odd loud hit
          stamp += (kind == 2) ? TIME_W'($urandom_range(1000, 70000))
                               : TIME_W'($urandom_range(1, 45));
          peak = ($urandom_range(0, 3) == 0) ? PEAK_BITS'($urandom_range(20000, 65535))
                                             : PEAK_BITS'($urandom_range(0, 18000));
        end
        offer_word(peak, stamp);

        // bursts of words separated by idle gaps of random length
        burst_left--;
        if (burst_left <= 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 32);
        end
      end
      quiesce();
    end

    // --- drain and verdict ---
    for (int c = 0; c < DRAIN_LIMIT && due != 0; c++) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due != 0) $display("%0t: %0d result words never arrived", $time, due);
    if (mismatches == 0 && due == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
